// ===== sv/c2e_pkg.sv =====
`default_nettype none

package c2e_pkg;

  // Year of the epoch and the leap days counted in years 1..1969.
  localparam logic [11:0] EpochYear        = 12'd1970;
  localparam logic [19:0] LeapsBeforeEpoch = 20'd477;

  // Range of years accepted as valid.
  localparam logic [11:0] YearMin = 12'd2000;
  localparam logic [11:0] YearMax = 12'd2099;

  localparam logic [8:0]  DaysPerYear = 9'd365;
  localparam logic [16:0] SecsPerDay  = 17'd86400;
  localparam logic [11:0] SecsPerHour = 12'd3600;
  localparam logic [5:0]  SecsPerMin  = 6'd60;

  // floor(n / 100) == (n * 5243) >> 19 holds for every n below 43690.
  localparam logic [12:0] Recip100      = 13'd5243;
  localparam int unsigned Recip100Shift = 19;

  localparam logic [3:0] MonthsPerYear = 4'd12;

  // Result of the calendar stage, handed to the final multiply stage.
  typedef struct packed {
    logic [19:0] days;        // whole days before the given date
    logic [31:0] tod;         // (day - 1) days plus time of day, in seconds
    logic        date_valid;
  } c2e_mid_t;

  // Quotient of a 12-bit value by 100, by reciprocal multiplication.
  function automatic logic [5:0] div100(input logic [11:0] n);
    logic [24:0] p;
    p = {13'b0, n} * {12'b0, Recip100};
    return p[Recip100Shift +: 6];
  endfunction

  // Days before the first of a month, for months already elapsed (0 to 12).
  function automatic logic [8:0] days_before_month(input logic leap,
                                                   input logic [3:0] months);
    logic [8:0] d;
    case (months)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd365;
    endcase
    // From March on, a leap year has one more day behind it.
    if (leap && (months >= 4'd2)) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== sv/c2e_if.sv =====
`default_nettype none

// Calendar date and time word.
interface c2e_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [2:0]  weekday;

  modport source (output valid, year, month, day, hour, minute, second, weekday,
                  input ready);
  modport sink   (input valid, year, month, day, hour, minute, second, weekday,
                  output ready);
endinterface

// Epoch seconds word.
interface c2e_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;
  logic        date_valid;

  modport source (output valid, epoch_seconds, date_valid, input ready);
  modport sink   (input valid, epoch_seconds, date_valid, output ready);
endinterface

`default_nettype wire

// ===== sv/c2e_days.sv =====
`default_nettype none

// Whole days from the epoch to the first day of the given month.
module c2e_days (
  input  wire logic [11:0] year,
  input  wire logic [3:0]  month,
  output logic      [19:0] days
);

  logic [11:0] year_m1;
  logic [11:0] whole;
  logic [5:0]  cent_prev;
  logic [5:0]  cent_cur;
  logic [19:0] leaps;
  logic [19:0] year_days;
  logic        leap;
  logic [3:0]  months;
  logic [11:0] cent_x100;

  always_comb begin
    year_m1 = year - 12'd1;
    whole   = year - c2e_pkg::EpochYear;

    // Leap years in 1970..year-1: n/4 - n/100 + n/400 with n = year-1,
    // less those before the epoch.
    cent_prev = c2e_pkg::div100(year_m1);
    leaps = {10'b0, year_m1[11:2]} - {14'b0, cent_prev} + {16'b0, cent_prev[5:2]}
            - c2e_pkg::LeapsBeforeEpoch;
    year_days = ({8'b0, whole} * {11'b0, c2e_pkg::DaysPerYear}) + leaps;
    if (year <= c2e_pkg::EpochYear) begin
      year_days = 20'd0;
    end

    // Gregorian rule for the given year itself.
    cent_cur  = c2e_pkg::div100(year);
    cent_x100 = {6'b0, cent_cur} * 12'd100;
    if (year[1:0] != 2'b00) begin
      leap = 1'b0;
    end else if (cent_x100 != year) begin
      leap = 1'b1;
    end else begin
      leap = (cent_cur[1:0] == 2'b00);
    end

    // Elapsed months; a month above twelve counts the whole year.
    months = (month == 4'd0) ? 4'd0 : (month - 4'd1);
    if (months > c2e_pkg::MonthsPerYear) begin
      months = c2e_pkg::MonthsPerYear;
    end

    days = year_days + {11'b0, c2e_pkg::days_before_month(leap, months)};
  end

endmodule

`default_nettype wire

// ===== sv/calendar_to_epoch_seconds.sv =====
// Converts one Gregorian calendar date and time per word into seconds since
// 1970-01-01 00:00:00 (modulo 2^32) plus a flag that says whether every field
// lies in its valid range (year 2000 to 2099, month 1 to 12, day 1 to 31,
// hour 0 to 23, minute and second 0 to 59, weekday 1 to 7). The weekday is
// only checked and never enters the count. The block takes one word per clock
// cycle while the output is not stalled and passes each word through the input
// register, then the calendar stage that counts the whole days and the seconds
// within the date, then the stage that scales the days to seconds with a single
// multiplier. Out-of-range fields are still converted at face value: a day of
// zero steps back one day, a month of zero adds no months and a month above
// twelve adds the whole year. Years up to 1970 add no year days. Both channels
// use a valid/ready handshake; when the output is stalled the three stages fill
// up before the input is held off.
`default_nettype none

module calendar_to_epoch_seconds (
  input  wire logic clk,
  input  wire logic rst_n,
  c2e_in_if.sink    in_ch,
  c2e_out_if.source out_ch
);

  // Input register.
  logic        s0_valid_r;
  logic [11:0] year_r;
  logic [3:0]  month_r;
  logic [4:0]  day_r;
  logic [4:0]  hour_r;
  logic [5:0]  minute_r;
  logic [5:0]  second_r;
  logic [2:0]  weekday_r;

  // Calendar stage register.
  logic               s1_valid_r;
  c2e_pkg::c2e_mid_t  mid_r;
  c2e_pkg::c2e_mid_t  mid_nxt;

  // Result register.
  logic        s2_valid_r;
  logic [31:0] epoch_seconds_r;
  logic        date_valid_r;
  logic [31:0] epoch_seconds_nxt;

  logic        s2_ready;
  logic        s1_ready;
  logic        s0_ready;
  logic [19:0] days;
  logic [36:0] day_secs;

  // A stage may take a new word when it is empty or its word moves on.
  assign s2_ready = !s2_valid_r || out_ch.ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign s0_ready = !s0_valid_r || s1_ready;

  assign in_ch.ready = s0_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (s0_ready) begin
      s0_valid_r <= in_ch.valid;
    end
    if (in_ch.valid && s0_ready) begin
      year_r    <= in_ch.year;
      month_r   <= in_ch.month;
      day_r     <= in_ch.day;
      hour_r    <= in_ch.hour;
      minute_r  <= in_ch.minute;
      second_r  <= in_ch.second;
      weekday_r <= in_ch.weekday;
    end
  end

  c2e_days u_days (
    .year  (year_r),
    .month (month_r),
    .days  (days)
  );

  // Seconds within the date: (day - 1) whole days, then the time of day.
  // A day of zero wraps back one day modulo 2^32.
  always_comb begin
    mid_nxt.days = days;
    mid_nxt.tod  = ({27'b0, day_r}    * {15'b0, c2e_pkg::SecsPerDay})
                 + ({27'b0, hour_r}   * {20'b0, c2e_pkg::SecsPerHour})
                 + ({26'b0, minute_r} * {26'b0, c2e_pkg::SecsPerMin})
                 + {26'b0, second_r}
                 - {15'b0, c2e_pkg::SecsPerDay};
    mid_nxt.date_valid = (second_r <= 6'd59) && (minute_r <= 6'd59) &&
                         (hour_r <= 5'd23) &&
                         (year_r >= c2e_pkg::YearMin) &&
                         (year_r <= c2e_pkg::YearMax) &&
                         (month_r != 4'd0) &&
                         (month_r <= c2e_pkg::MonthsPerYear) &&
                         (day_r != 5'd0) &&
                         (weekday_r != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= s0_valid_r;
    end
    if (s0_valid_r && s1_ready) begin
      mid_r <= mid_nxt;
    end
  end

  // Scale the whole days to seconds and add the seconds within the date.
  always_comb begin
    day_secs          = {17'b0, mid_r.days} * {20'b0, c2e_pkg::SecsPerDay};
    epoch_seconds_nxt = day_secs[31:0] + mid_r.tod;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
    if (s1_valid_r && s2_ready) begin
      epoch_seconds_r <= epoch_seconds_nxt;
      date_valid_r    <= mid_r.date_valid;
    end
  end

  assign out_ch.valid         = s2_valid_r;
  assign out_ch.epoch_seconds = epoch_seconds_r;
  assign out_ch.date_valid    = date_valid_r;

endmodule

`default_nettype wire
